@@ hw/rtl/acc_pkg.sv @@
// shared types, constants and arctangent table for the tilt angle pipeline
package acc_pkg;

	localparam int SAMPLE_BITS   = 16;
	localparam int CORDIC_STAGES = 16;
	localparam int SQ_W          = 2 * SAMPLE_BITS;
	localparam int ROOT_W        = SAMPLE_BITS;
	localparam int PRE_SHIFT     = 60 - SAMPLE_BITS;
	localparam int CW            = 63;
	localparam int ZW            = 25;
	localparam int ANG_W         = 17;
	localparam int OFF_W         = 16;
	localparam int OUT_LIMIT     = 46080;
	localparam int IN_TDATA_W    = ((3 * SAMPLE_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W   = 40;
	localparam int REG_IDX_W     = 1;

	typedef logic [REG_IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_OFFSET_X = 1'b0;
	localparam reg_idx_t REG_OFFSET_Y = 1'b1;

	typedef struct packed {
		logic [SQ_W-1:0]               rad_x;
		logic [SQ_W-1:0]               rad_y;
		logic signed [SAMPLE_BITS-1:0] num_x;
		logic signed [SAMPLE_BITS-1:0] num_y;
	} acc_rad_t;

	typedef struct packed {
		logic [ROOT_W-1:0]             den_x;
		logic [ROOT_W-1:0]             den_y;
		logic signed [SAMPLE_BITS-1:0] num_x;
		logic signed [SAMPLE_BITS-1:0] num_y;
	} acc_vec_t;

	typedef struct packed {
		logic signed [ANG_W-1:0] ang_x;
		logic signed [ANG_W-1:0] ang_y;
	} acc_ang_t;

	// atan(2^-i) in 1/65536 degree
	function automatic logic signed [ZW-1:0] atan_entry(input int unsigned i);
		logic signed [ZW-1:0] t;
		unique case (i)
			0: t = ZW'(2949120);
			1: t = ZW'(1740967);
			2: t = ZW'(919879);
			3: t = ZW'(466945);
			4: t = ZW'(234379);
			5: t = ZW'(117304);
			6: t = ZW'(58666);
			7: t = ZW'(29335);
			8: t = ZW'(14668);
			9: t = ZW'(7334);
			10: t = ZW'(3667);
			11: t = ZW'(1833);
			12: t = ZW'(917);
			13: t = ZW'(458);
			14: t = ZW'(229);
			15: t = ZW'(115);
			16: t = ZW'(57);
			17: t = ZW'(29);
			18: t = ZW'(14);
			19: t = ZW'(7);
			20: t = ZW'(4);
			21: t = ZW'(2);
			22: t = ZW'(1);
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

@@ hw/rtl/acc_isqrt.sv @@
// pipelined integer square root, two lanes, one result bit per stage
module acc_isqrt (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  acc_pkg::acc_rad_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output acc_pkg::acc_vec_t out_data
);

	localparam int N = acc_pkg::ROOT_W;
	localparam int W = acc_pkg::SQ_W;
	localparam int S = acc_pkg::SAMPLE_BITS;

	typedef struct packed {
		logic [W-1:0] rem;
		logic [W-1:0] root;
	} sqrt_pair_t;

	function automatic sqrt_pair_t sqrt_step(input logic [W-1:0] v, input logic [W-1:0] r,
			input int unsigned k);
		logic [W-1:0] b;
		logic [W:0]   t;
		sqrt_pair_t   p;
		b = W'(1) << (W - 2 - 2 * k);
		t = {1'b0, r} + {1'b0, b};
		if ({1'b0, v} >= t) begin
			p.rem  = v - t[W-1:0];
			p.root = (r >> 1) + b;
		end else begin
			p.rem  = v;
			p.root = r >> 1;
		end
		return p;
	endfunction

	logic                vld_s  [N];
	logic                rdy    [N+1];
	logic [W-1:0]        rem_x_s [N];
	logic [W-1:0]        root_x_s[N];
	logic [W-1:0]        rem_y_s [N];
	logic [W-1:0]        root_y_s[N];
	logic signed [S-1:0] num_x_s [N];
	logic signed [S-1:0] num_y_s [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [W-1:0]        vx, rx, vy, ry;
		logic signed [S-1:0] nx, ny;
		logic                vin;
		sqrt_pair_t          px, py;

		if (k == 0) begin : g_first
			assign vx  = in_data.rad_x;
			assign rx  = '0;
			assign vy  = in_data.rad_y;
			assign ry  = '0;
			assign nx  = in_data.num_x;
			assign ny  = in_data.num_y;
			assign vin = in_valid;
		end else begin : g_next
			assign vx  = rem_x_s[k-1];
			assign rx  = root_x_s[k-1];
			assign vy  = rem_y_s[k-1];
			assign ry  = root_y_s[k-1];
			assign nx  = num_x_s[k-1];
			assign ny  = num_y_s[k-1];
			assign vin = vld_s[k-1];
		end

		always_comb begin
			px = sqrt_step(vx, rx, k);
			py = sqrt_step(vy, ry, k);
		end

		assign rdy[k] = !vld_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				rem_x_s[k]  <= px.rem;
				root_x_s[k] <= px.root;
				rem_y_s[k]  <= py.rem;
				root_y_s[k] <= py.root;
				num_x_s[k]  <= nx;
				num_y_s[k]  <= ny;
			end
		end
	end

	assign rdy[N]         = out_ready;
	assign in_ready       = rdy[0];
	assign out_valid      = vld_s[N-1];
	assign out_data.den_x = root_x_s[N-1][N-1:0];
	assign out_data.den_y = root_y_s[N-1][N-1:0];
	assign out_data.num_x = num_x_s[N-1];
	assign out_data.num_y = num_y_s[N-1];

endmodule

@@ hw/rtl/acc_cordic.sv @@
// pipelined vectoring cordic, two lanes, one rotation per stage, then rounding
module acc_cordic (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  acc_pkg::acc_vec_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output acc_pkg::acc_ang_t out_data
);

	localparam int N  = acc_pkg::CORDIC_STAGES;
	localparam int CW = acc_pkg::CW;
	localparam int ZW = acc_pkg::ZW;
	localparam int AW = acc_pkg::ANG_W;

	function automatic logic signed [AW-1:0] round_ang(input logic signed [ZW-1:0] z,
			input logic zero);
		logic [ZW:0] m;
		logic [ZW:0] q;
		m = z[ZW-1] ? (ZW+1)'(-{z[ZW-1], z}) : {1'b0, z};
		q = (m + (ZW+1)'(128)) >> 8;
		if (zero) begin
			return '0;
		end else if (z[ZW-1]) begin
			return AW'(-q);
		end else begin
			return AW'(q);
		end
	endfunction

	logic                 vld_s [N];
	logic                 rdy   [N+1];
	logic signed [CW-1:0] cx_s  [N][2];
	logic signed [CW-1:0] cy_s  [N][2];
	logic signed [ZW-1:0] z_s   [N][2];
	logic                 zf_s  [N][2];
	logic                 rnd_vld_s;
	acc_pkg::acc_ang_t    rnd_s;

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic signed [CW-1:0] cxi [2];
		logic signed [CW-1:0] cyi [2];
		logic signed [ZW-1:0] zi  [2];
		logic                 zfi [2];
		logic signed [CW-1:0] cxo [2];
		logic signed [CW-1:0] cyo [2];
		logic signed [ZW-1:0] zo  [2];
		logic                 vin;

		if (k == 0) begin : g_first
			assign cxi[0] = CW'({1'b0, in_data.den_x}) <<< acc_pkg::PRE_SHIFT;
			assign cyi[0] = CW'(in_data.num_x) <<< acc_pkg::PRE_SHIFT;
			assign cxi[1] = CW'({1'b0, in_data.den_y}) <<< acc_pkg::PRE_SHIFT;
			assign cyi[1] = CW'(in_data.num_y) <<< acc_pkg::PRE_SHIFT;
			assign zi[0]  = '0;
			assign zi[1]  = '0;
			assign zfi[0] = (in_data.num_x == '0) && (in_data.den_x == '0);
			assign zfi[1] = (in_data.num_y == '0) && (in_data.den_y == '0);
			assign vin    = in_valid;
		end else begin : g_next
			for (genvar l = 0; l < 2; l++) begin : g_lane
				assign cxi[l] = cx_s[k-1][l];
				assign cyi[l] = cy_s[k-1][l];
				assign zi[l]  = z_s[k-1][l];
				assign zfi[l] = zf_s[k-1][l];
			end
			assign vin = vld_s[k-1];
		end

		for (genvar l = 0; l < 2; l++) begin : g_rot
			always_comb begin
				if (!cyi[l][CW-1]) begin
					cxo[l] = cxi[l] + (cyi[l] >>> k);
					cyo[l] = cyi[l] - (cxi[l] >>> k);
					zo[l]  = zi[l] + acc_pkg::atan_entry(k);
				end else begin
					cxo[l] = cxi[l] - (cyi[l] >>> k);
					cyo[l] = cyi[l] + (cxi[l] >>> k);
					zo[l]  = zi[l] - acc_pkg::atan_entry(k);
				end
			end

			always_ff @(posedge clk) begin
				if (rdy[k]) begin
					cx_s[k][l] <= cxo[l];
					cy_s[k][l] <= cyo[l];
					z_s[k][l]  <= zo[l];
					zf_s[k][l] <= zfi[l];
				end
			end
		end

		assign rdy[k] = !vld_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= vin;
			end
		end
	end

	assign rdy[N] = !rnd_vld_s || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_vld_s <= 1'b0;
		end else if (rdy[N]) begin
			rnd_vld_s <= vld_s[N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[N]) begin
			rnd_s.ang_x <= round_ang(z_s[N-1][0], zf_s[N-1][0]);
			rnd_s.ang_y <= round_ang(z_s[N-1][1], zf_s[N-1][1]);
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = rnd_vld_s;
	assign out_data  = rnd_s;

endmodule

@@ hw/rtl/accel_tilt_angles.sv @@
// top level: squares, norms, cordic arctangents, offset and saturation
// Takes one sample per clock while the output side is ready and gives one result per
// sample, in order, through the squares and sums registers, the square root stages, the
// cordic rotation stages, the rounding register and the offset and saturation register.
// Every stage holds its transaction under back-pressure, so throughput is one transaction
// per cycle whenever the output side is ready. Offsets are applied at the output stage
// and should be written while the pipeline is empty.
module accel_tilt_angles (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// accel_x, accel_y, accel_z
	input  logic [acc_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// tilt_x, tilt_y, zero pad
	output logic [acc_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input  logic                                cfg_we,
	input  acc_pkg::reg_idx_t                   cfg_addr,
	input  logic [acc_pkg::OFF_W-1:0]           cfg_wdata
);

	localparam int S  = acc_pkg::SAMPLE_BITS;
	localparam int QW = acc_pkg::SQ_W;
	localparam int AW = acc_pkg::ANG_W;

	function automatic logic [S-1:0] mag(input logic signed [S-1:0] a);
		return a[S-1] ? S'(-a) : a;
	endfunction

	function automatic logic signed [AW-1:0] sat(input logic signed [AW:0] d);
		if (d > acc_pkg::OUT_LIMIT) begin
			return AW'(acc_pkg::OUT_LIMIT);
		end else if (d < -acc_pkg::OUT_LIMIT) begin
			return AW'(-acc_pkg::OUT_LIMIT);
		end else begin
			return AW'(d);
		end
	endfunction

	logic signed [acc_pkg::OFF_W-1:0] off_x_q, off_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q <= '0;
			off_y_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				acc_pkg::REG_OFFSET_X: off_x_q <= cfg_wdata;
				acc_pkg::REG_OFFSET_Y: off_y_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic signed [S-1:0] ax, ay, az;
	assign ax = s_tdata[S-1:0];
	assign ay = s_tdata[2*S-1:S];
	assign az = s_tdata[3*S-1:2*S];

	// squares
	logic                vld_s1, rdy1;
	logic [QW-1:0]       sqx_s1, sqy_s1, sqz_s1;
	logic signed [S-1:0] x_s1, y_s1;
	// sums
	logic                vld_s2, rdy2;
	acc_pkg::acc_rad_t   rad_s2;

	logic                sq_ready, co_valid, co_in_ready, rdy3;
	acc_pkg::acc_vec_t   vec;
	logic                vec_valid;
	acc_pkg::acc_ang_t   ang;

	logic                    vld_s3;
	logic signed [AW-1:0]    tilt_x_s3, tilt_y_s3;

	assign rdy3     = !vld_s3 || m_tready;
	assign rdy2     = !vld_s2 || sq_ready;
	assign rdy1     = !vld_s1 || rdy2;
	assign s_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy1) begin
				vld_s1 <= s_tvalid;
			end
			if (rdy2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			sqx_s1 <= QW'(mag(ax)) * QW'(mag(ax));
			sqy_s1 <= QW'(mag(ay)) * QW'(mag(ay));
			sqz_s1 <= QW'(mag(az)) * QW'(mag(az));
			x_s1   <= ax;
			y_s1   <= ay;
		end
		if (rdy2) begin
			rad_s2.rad_x <= sqy_s1 + sqz_s1;
			rad_s2.rad_y <= sqx_s1 + sqz_s1;
			rad_s2.num_x <= x_s1;
			rad_s2.num_y <= y_s1;
		end
	end

	acc_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.in_ready  (sq_ready),
		.in_data   (rad_s2),
		.out_valid (vec_valid),
		.out_ready (co_in_ready),
		.out_data  (vec)
	);

	acc_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vec_valid),
		.in_ready  (co_in_ready),
		.in_data   (vec),
		.out_valid (co_valid),
		.out_ready (rdy3),
		.out_data  (ang)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (rdy3) begin
			vld_s3 <= co_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			tilt_x_s3 <= sat((AW+1)'(ang.ang_x) - (AW+1)'(off_x_q));
			tilt_y_s3 <= sat(-(AW+1)'(ang.ang_y) - (AW+1)'(off_y_q));
		end
	end

	assign m_tvalid = vld_s3;
	assign m_tdata  = {(acc_pkg::OUT_TDATA_W - 2 * AW)'(0), tilt_y_s3, tilt_x_s3};

endmodule

@@ hw/rtl/acc_checker.sv @@
// port level checks for the tilt angle block and their binding
module acc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [acc_pkg::OUT_TDATA_W-1:0] m_tdata
);

	localparam int AW = acc_pkg::ANG_W;

	logic signed [AW-1:0] tx, ty;
	assign tx = m_tdata[AW-1:0];
	assign ty = m_tdata[2*AW-1:AW];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> tx <= acc_pkg::OUT_LIMIT && tx >= -acc_pkg::OUT_LIMIT
			&& ty <= acc_pkg::OUT_LIMIT && ty >= -acc_pkg::OUT_LIMIT)
		else $error("angle outside saturation range");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[acc_pkg::OUT_TDATA_W-1:2*AW] == '0)
		else $error("pad bits not zero");

endmodule

bind accel_tilt_angles acc_checker u_acc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

@@ verif/tb_top.sv @@
// testbench for the tilt angle pipeline: directed table, random samples, scoreboard
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY   = 36;
	localparam int WD_LIMIT  = 5000;
	localparam int N_RANDOM  = 830;
	localparam int ATAN_TBL[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
		58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

	typedef struct packed {
		logic signed [16:0] tilt_y;
		logic signed [16:0] tilt_x;
	} tilt_t;

	typedef struct {
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		bit                 known;
		int                 ex;
		int                 ey;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [acc_pkg::IN_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [acc_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	acc_pkg::reg_idx_t cfg_addr = acc_pkg::REG_OFFSET_X;
	logic [acc_pkg::OFF_W-1:0] cfg_wdata = '0;

	always #6 clk = ~clk;

	accel_tilt_angles dut (.*);

	tilt_t tilt_q[$];
	logic signed [15:0] off_x = 0;
	logic signed [15:0] off_y = 0;
	int n_errors = 0;
	int n_results = 0;
	int n_sent = 0;
	int src_idle = 28;
	int snk_idle = 50;
	bit snk_hold = 1'b0;
	int idle_cnt = 0;

	function automatic longint isqrt64(longint unsigned v);
		longint unsigned r = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint vector_angle(longint num, longint den);
		longint cx, cy, dx, dy;
		longint z = 0;
		if (num == 0 && den == 0) return 0;
		cx = den <<< (60 - acc_pkg::SAMPLE_BITS);
		cy = num <<< (60 - acc_pkg::SAMPLE_BITS);
		for (int i = 0; i < acc_pkg::CORDIC_STAGES; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (cy >= 0) begin
				cx += dx;
				cy -= dy;
				z += ATAN_TBL[i];
			end else begin
				cx -= dx;
				cy += dy;
				z -= ATAN_TBL[i];
			end
		end
		if (z >= 0) return (z + 128) >>> 8;
		return -((-z + 128) >>> 8);
	endfunction

	function automatic logic signed [16:0] clamp_angle(longint v);
		if (v > acc_pkg::OUT_LIMIT) v = acc_pkg::OUT_LIMIT;
		if (v < -acc_pkg::OUT_LIMIT) v = -acc_pkg::OUT_LIMIT;
		return 17'(v);
	endfunction

	function automatic tilt_t predict_tilt(logic signed [15:0] x, logic signed [15:0] y,
			logic signed [15:0] z);
		longint lx = x;
		longint ly = y;
		longint lz = z;
		tilt_t t;
		t.tilt_x = clamp_angle(vector_angle(lx, isqrt64(ly * ly + lz * lz)) - off_x);
		t.tilt_y = clamp_angle(-vector_angle(ly, isqrt64(lx * lx + lz * lz)) - off_y);
		return t;
	endfunction

	task automatic send_sample(row_t r);
		tilt_t t;
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		t = predict_tilt(r.ax, r.ay, r.az);
		if (r.known) begin
			if (t.tilt_x != r.ex) begin
				$error("table tilt_x exp %0d pred %0d", r.ex, t.tilt_x);
				n_errors++;
			end
			if (t.tilt_y != r.ey) begin
				$error("table tilt_y exp %0d pred %0d", r.ey, t.tilt_y);
				n_errors++;
			end
			t.tilt_x = 17'(r.ex);
			t.tilt_y = 17'(r.ey);
		end
		tilt_q.push_back(t);
		s_tvalid <= 1'b1;
		s_tdata <= {r.az, r.ay, r.ax};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		n_sent++;
	endtask

	task automatic drain_and_settle();
		s_tvalid <= 1'b0;
		while (tilt_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_offset(acc_pkg::reg_idx_t idx, logic signed [15:0] v);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == acc_pkg::REG_OFFSET_X) off_x = v;
		else off_y = v;
		@(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_axis();
		case ($urandom_range(9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'(int'($urandom_range(8)) - 4);
			3: return 16'($urandom_range(4096) - 2048);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_burst(int n);
		row_t r;
		for (int i = 0; i < n; i++) begin
			r.ax = rand_axis();
			r.ay = rand_axis();
			r.az = rand_axis();
			r.known = 1'b0;
			send_sample(r);
		end
	endtask

	// result checking
	always @(posedge clk) begin
		tilt_t got, exp_t;
		if (m_tvalid && m_tready) begin
			got = m_tdata[33:0];
			n_results++;
			if (tilt_q.size() == 0) begin
				$error("unexpected transaction tdata %h", m_tdata);
				n_errors++;
			end else begin
				exp_t = tilt_q.pop_front();
				if (got.tilt_x !== exp_t.tilt_x) begin
					$error("tilt_x exp %0d got %0d", exp_t.tilt_x, got.tilt_x);
					n_errors++;
				end
				if (got.tilt_y !== exp_t.tilt_y) begin
					$error("tilt_y exp %0d got %0d", exp_t.tilt_y, got.tilt_y);
					n_errors++;
				end
				if (m_tdata[39:34] !== '0) begin
					$error("pad exp 0 got %h", m_tdata[39:34]);
					n_errors++;
				end
			end
		end
	end

	// receiver
	always @(posedge clk) begin
		if (!arst_n) m_tready <= 1'b0;
		else m_tready <= !snk_hold && ($urandom_range(99) >= snk_idle);
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || tilt_q.size() == 0)
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt > WD_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	row_t dir_tbl[$];

	function automatic row_t mk(int x, int y, int z, bit k = 0, int ex = 0, int ey = 0);
		row_t r;
		r.ax = 16'(x);
		r.ay = 16'(y);
		r.az = 16'(z);
		r.known = k;
		r.ex = ex;
		r.ey = ey;
		return r;
	endfunction

	initial begin
		dir_tbl = '{mk(0, 0, 0, 1, 0, 0), mk(0, 0, 1000, 1, 0, 0), mk(0, 0, -32768, 1, 0, 0),
			mk(32767, 0, 0), mk(-32768, 0, 0), mk(0, 32767, 0), mk(0, -32768, 0),
			mk(32767, 32767, 32767), mk(-32768, -32768, -32768), mk(1, 0, 0), mk(-1, 0, 0),
			mk(0, 1, 0), mk(0, -1, 0), mk(100, 100, 0), mk(-100, 100, 0),
			mk(16384, -16384, 16384), mk(-1, -1, -1), mk(32767, -32768, 0),
			mk(5, 3, -7)};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_tbl[i]) send_sample(dir_tbl[i]);
		drain_and_settle();
		// extreme offsets drive each angle in turn to its saturation limit
		write_offset(acc_pkg::REG_OFFSET_X, -16'sd23040);
		write_offset(acc_pkg::REG_OFFSET_Y, 16'sd23040);
		send_sample(mk(32767, 0, 0, 1, 46080, -23040));
		send_sample(mk(0, 32767, 0, 1, 23040, -46080));
		random_burst(100);
		drain_and_settle();
		write_offset(acc_pkg::REG_OFFSET_X, 16'sd23040);
		write_offset(acc_pkg::REG_OFFSET_Y, -16'sd32768);
		random_burst(100);
		drain_and_settle();
		src_idle = 50;
		snk_idle = 28;
		write_offset(acc_pkg::REG_OFFSET_X, 16'(int'($urandom_range(46080)) - 23040));
		write_offset(acc_pkg::REG_OFFSET_Y, 16'sh7fff);
		random_burst(200);
		// long receiver hold-off while samples keep coming
		fork
			begin
				snk_hold = 1'b1;
				repeat (150) @(posedge clk);
				snk_hold = 1'b0;
			end
			random_burst(80);
		join
		drain_and_settle();
		src_idle = 0;
		snk_idle = 0;
		write_offset(acc_pkg::REG_OFFSET_X, 16'($urandom));
		write_offset(acc_pkg::REG_OFFSET_Y, 16'(int'($urandom_range(46080)) - 23040));
		random_burst(N_RANDOM - 480);
		drain_and_settle();
		$display("covered %0d samples, %0d results, offsets swept to both extremes", n_sent,
			n_results);
		$display("idling on both sides, long output stall and full drain exercised");
		if (n_errors == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end
endmodule

@@ accel_tilt_angles.f @@
hw/rtl/acc_pkg.sv
hw/rtl/acc_isqrt.sv
hw/rtl/acc_cordic.sv
hw/rtl/accel_tilt_angles.sv
hw/rtl/acc_checker.sv
verif/tb_top.sv
